FILE: hdl/jsfd_pkg.sv
// shared types and constants for the joystick scale, filter and direction block
`timescale 1ns / 1ps

package jsfd_pkg;

    localparam int SAMPLE_W     = 10;
    localparam int DB_W         = 7;
    localparam int AVG_W        = 8;
    localparam int HEAD_W       = 3;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 10;
    localparam int IN_TDATA_W   = 24;
    localparam int OUT_TDATA_W  = 24;

    // divider: 18-bit dividend, 10-bit divisor, two quotient bits per cycle
    localparam int DIV_NUM_W    = 18;
    localparam int DIV_DEN_W    = 10;
    localparam int DIV_STEPS    = DIV_NUM_W / 2;
    localparam int DIV_CNT_W    = $clog2(DIV_STEPS + 1);

    localparam int SCALE_SPAN   = 200;
    localparam int SCALE_OFFSET = 100;
    localparam int SCALE_MAX    = 100;

    localparam logic [CFG_IDX_W-1:0] CFG_X_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_X_HIGH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_LOW     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_HIGH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_BAND = 3'd4;

    localparam logic [HEAD_W-1:0] HEAD_NEUTRAL  = 3'd0;
    localparam logic [HEAD_W-1:0] HEAD_FORWARD  = 3'd1;
    localparam logic [HEAD_W-1:0] HEAD_BACKWARD = 3'd2;
    localparam logic [HEAD_W-1:0] HEAD_RIGHT    = 3'd3;
    localparam logic [HEAD_W-1:0] HEAD_LEFT     = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCALE,
        ST_UPDATE,
        ST_AVG_LOAD,
        ST_AVG,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic capture;
        logic scale_start;
        logic update;
        logic avg_start;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } ctrl_sts_t;

endpackage

FILE: hdl/joystick_scale_filter_direction.sv
// top level: joystick scaling, moving-average filter and heading classifier
`timescale 1ns / 1ps

// Each input item carries one raw (x, y) sample pair. Samples are clamped to
// the calibrated range, scaled to -100..100, averaged over a WINDOW-entry
// history and classified into a heading. Each item makes two passes through a
// pair of radix-4 dividers (nine steps each; one pass for scaling and one for
// the window average), with sequencing states around them. The next item can
// be accepted in the cycle after the result is loaded, so items are taken one
// at a time. A finished result sits in an output register, so the next item
// is accepted while it waits; a result still waiting when the next one
// finishes holds that one in its last cycle. The history is cleared by reset
// with no sweep. Configuration must be written through
// cfg_we/cfg_index/cfg_data only while the block is idle; the block itself
// does not enforce this. Indexes past the dead band register are ignored.
module joystick_scale_filter_direction #(
    parameter int WINDOW = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // fields from bit 0: x_raw, y_raw, zero fill
    input  logic [jsfd_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // fields from bit 0: x_avg, y_avg, heading, zero fill
    output logic [jsfd_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                             cfg_we,
    input  logic [jsfd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [jsfd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import jsfd_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    jsfd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    jsfd_datapath #(
        .WINDOW (WINDOW)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

FILE: hdl/jsfd_divider.sv
// restoring divider, two quotient bits per cycle
`timescale 1ns / 1ps

module jsfd_divider (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [jsfd_pkg::DIV_NUM_W-1:0] num,
    input  logic [jsfd_pkg::DIV_DEN_W-1:0] den,
    output logic [jsfd_pkg::DIV_NUM_W-1:0] quot,
    output logic                           done
);
    import jsfd_pkg::*;

    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_NUM_W-1:0] quot_reg, quot_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_DEN_W:0]   part_a, part_b;
    logic [DIV_DEN_W-1:0] rem_a;
    logic                 ge_a, ge_b;

    always_comb
    begin
        part_a = {rem_reg, quot_reg[DIV_NUM_W-1]};
        ge_a   = part_a >= {1'b0, den_reg};
        rem_a  = ge_a ? DIV_DEN_W'(part_a - {1'b0, den_reg}) : part_a[DIV_DEN_W-1:0];
        part_b = {rem_a, quot_reg[DIV_NUM_W-2]};
        ge_b   = part_b >= {1'b0, den_reg};
        rem_next  = ge_b ? DIV_DEN_W'(part_b - {1'b0, den_reg}) : part_b[DIV_DEN_W-1:0];
        quot_next = {quot_reg[DIV_NUM_W-3:0], ge_a, ge_b};
        cnt_next  = cnt_reg - DIV_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= DIV_CNT_W'(DIV_STEPS);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= num;
            rem_reg  <= '0;
            den_reg  <= den;
        end
        else if (cnt_reg != '0)
        begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
    end

    assign quot = quot_reg;
    assign done = (cnt_reg == '0);

endmodule

FILE: hdl/jsfd_datapath.sv
// scaling, window averaging, heading and output register
`timescale 1ns / 1ps

module jsfd_datapath #(
    parameter int WINDOW = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  jsfd_pkg::ctrl_cmd_t              cmd,
    output jsfd_pkg::ctrl_sts_t              sts,
    input  logic [jsfd_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [jsfd_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                             cfg_we,
    input  logic [jsfd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [jsfd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import jsfd_pkg::*;

    localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int TOT_W = $clog2(WINDOW * SCALE_MAX + 1) + 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW - 1);

    function automatic logic [DIV_NUM_W-1:0] scale_num(
        input logic [SAMPLE_W-1:0] s,
        input logic [SAMPLE_W-1:0] lo,
        input logic [SAMPLE_W-1:0] hi
    );
        logic [SAMPLE_W-1:0] s1;
        logic [SAMPLE_W-1:0] s2;
        s1 = (s < lo) ? lo : s;
        s2 = (s1 > hi) ? hi : s1;
        return DIV_NUM_W'(s2 - lo) * DIV_NUM_W'(SCALE_SPAN);
    endfunction

    function automatic logic [HEAD_W-1:0] classify(
        input logic signed [AVG_W-1:0] xa,
        input logic signed [AVG_W-1:0] ya,
        input logic [DB_W-1:0]         db
    );
        logic [AVG_W-1:0] ax;
        logic [AVG_W-1:0] ay;
        logic [HEAD_W-1:0] h;
        ax = xa[AVG_W-1] ? AVG_W'(-xa) : AVG_W'(xa);
        ay = ya[AVG_W-1] ? AVG_W'(-ya) : AVG_W'(ya);
        if (ax >= ay)
            h = (ax < AVG_W'(db)) ? HEAD_NEUTRAL : (xa[AVG_W-1] ? HEAD_LEFT : HEAD_RIGHT);
        else
            h = (ay < AVG_W'(db)) ? HEAD_NEUTRAL : (ya[AVG_W-1] ? HEAD_FORWARD : HEAD_BACKWARD);
        return h;
    endfunction

    // configuration
    logic [SAMPLE_W-1:0] x_low_reg, x_high_reg, y_low_reg, y_high_reg;
    logic [DB_W-1:0]     dead_band_reg;

    // item and window state
    logic [SAMPLE_W-1:0]     x_raw_reg, y_raw_reg;
    logic                    x_empty_reg, y_empty_reg;
    logic [PTR_W-1:0]        ptr_reg, ptr_next;
    logic [WINDOW-1:0]       hvalid_reg;
    logic [2*AVG_W-1:0]      hist_mem [WINDOW];
    logic [2*AVG_W-1:0]      hist_rd_reg;
    logic                    hist_rd_valid_reg;
    logic signed [TOT_W-1:0] x_total_reg, x_total_next;
    logic signed [TOT_W-1:0] y_total_reg, y_total_next;

    // output register
    logic                    out_valid_reg, out_valid_next;
    logic signed [AVG_W-1:0] x_avg_reg, y_avg_reg;
    logic [HEAD_W-1:0]       head_reg;

    logic signed [AVG_W-1:0] x_val, y_val, x_old, y_old, x_avg_c, y_avg_c;
    logic [TOT_W-1:0]        x_mag, y_mag;
    logic [DIV_NUM_W-1:0]    x_num, y_num, x_quot, y_quot;
    logic [DIV_DEN_W-1:0]    x_den, y_den;
    logic                    x_done, y_done, div_start;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_low_reg     <= '0;
            x_high_reg    <= '1;
            y_low_reg     <= '0;
            y_high_reg    <= '1;
            dead_band_reg <= DB_W'(10);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_X_LOW:     x_low_reg     <= cfg_data[SAMPLE_W-1:0];
                CFG_X_HIGH:    x_high_reg    <= cfg_data[SAMPLE_W-1:0];
                CFG_Y_LOW:     y_low_reg     <= cfg_data[SAMPLE_W-1:0];
                CFG_Y_HIGH:    y_high_reg    <= cfg_data[SAMPLE_W-1:0];
                CFG_DEAD_BAND: dead_band_reg <= cfg_data[DB_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            x_raw_reg <= s_tdata[SAMPLE_W-1:0];
            y_raw_reg <= s_tdata[2*SAMPLE_W-1:SAMPLE_W];
        end
        if (cmd.scale_start)
        begin
            x_empty_reg <= (x_high_reg <= x_low_reg);
            y_empty_reg <= (y_high_reg <= y_low_reg);
        end
    end

    // window history memory, registered read at the slot pointer
    always_ff @(posedge clk)
    begin
        if (cmd.scale_start)
            hist_rd_reg <= hist_mem[ptr_reg];
        if (cmd.update)
            hist_mem[ptr_reg] <= {y_val, x_val};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hvalid_reg        <= '0;
            hist_rd_valid_reg <= 1'b0;
            ptr_reg           <= '0;
            x_total_reg       <= '0;
            y_total_reg       <= '0;
        end
        else
        begin
            if (cmd.scale_start)
                hist_rd_valid_reg <= hvalid_reg[ptr_reg];
            if (cmd.update)
            begin
                hvalid_reg[ptr_reg] <= 1'b1;
                ptr_reg             <= ptr_next;
                x_total_reg         <= x_total_next;
                y_total_reg         <= y_total_next;
            end
        end
    end

    always_comb
    begin
        // quotient is at most 200, so the low byte minus the offset is exact
        x_val = x_empty_reg ? '0 : $signed(AVG_W'(x_quot[AVG_W-1:0] - AVG_W'(SCALE_OFFSET)));
        y_val = y_empty_reg ? '0 : $signed(AVG_W'(y_quot[AVG_W-1:0] - AVG_W'(SCALE_OFFSET)));
        x_old = hist_rd_valid_reg ? $signed(hist_rd_reg[AVG_W-1:0]) : '0;
        y_old = hist_rd_valid_reg ? $signed(hist_rd_reg[2*AVG_W-1:AVG_W]) : '0;
        x_total_next = x_total_reg - TOT_W'(x_old) + TOT_W'(x_val);
        y_total_next = y_total_reg - TOT_W'(y_old) + TOT_W'(y_val);
        ptr_next = (ptr_reg == PTR_LAST) ? '0 : ptr_reg + PTR_W'(1);

        x_mag = x_total_reg[TOT_W-1] ? TOT_W'(-x_total_reg) : TOT_W'(x_total_reg);
        y_mag = y_total_reg[TOT_W-1] ? TOT_W'(-y_total_reg) : TOT_W'(y_total_reg);

        div_start = cmd.scale_start | cmd.avg_start;
        if (cmd.avg_start)
        begin
            x_num = DIV_NUM_W'(x_mag);
            y_num = DIV_NUM_W'(y_mag);
            x_den = DIV_DEN_W'(WINDOW);
            y_den = DIV_DEN_W'(WINDOW);
        end
        else
        begin
            x_num = scale_num(x_raw_reg, x_low_reg, x_high_reg);
            y_num = scale_num(y_raw_reg, y_low_reg, y_high_reg);
            x_den = DIV_DEN_W'(x_high_reg - x_low_reg);
            y_den = DIV_DEN_W'(y_high_reg - y_low_reg);
        end

        // truncation toward zero: divide the magnitude, then restore the sign
        x_avg_c = x_total_reg[TOT_W-1] ? $signed(AVG_W'(-x_quot[AVG_W-1:0]))
                                       : $signed(x_quot[AVG_W-1:0]);
        y_avg_c = y_total_reg[TOT_W-1] ? $signed(AVG_W'(-y_quot[AVG_W-1:0]))
                                       : $signed(y_quot[AVG_W-1:0]);
    end

    jsfd_divider u_div_x (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (x_num),
        .den   (x_den),
        .quot  (x_quot),
        .done  (x_done)
    );

    jsfd_divider u_div_y (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (y_num),
        .den   (y_den),
        .quot  (y_quot),
        .done  (y_done)
    );

    assign out_valid_next = cmd.out_load | (out_valid_reg & ~m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            x_avg_reg <= x_avg_c;
            y_avg_reg <= y_avg_c;
            head_reg  <= classify(x_avg_c, y_avg_c, dead_band_reg);
        end
    end

    assign sts.div_done = x_done & y_done;
    assign sts.out_free = ~out_valid_reg | m_tready;
    assign m_tvalid     = out_valid_reg;
    // fields from bit 0: x_avg, y_avg, heading, zero fill
    assign m_tdata = {{(OUT_TDATA_W - 2*AVG_W - HEAD_W){1'b0}}, head_reg, y_avg_reg, x_avg_reg};

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= PTR_LAST)
        else $error("slot pointer past window end");

    a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |=> (x_total_reg <= TOT_W'(WINDOW * SCALE_MAX)) &&
                       (x_total_reg >= -TOT_W'(WINDOW * SCALE_MAX)) &&
                       (y_total_reg <= TOT_W'(WINDOW * SCALE_MAX)) &&
                       (y_total_reg >= -TOT_W'(WINDOW * SCALE_MAX)))
        else $error("running sum out of range");

    a_avg_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> (x_avg_reg <= AVG_W'(SCALE_MAX)) &&
                         (x_avg_reg >= -AVG_W'(SCALE_MAX)) &&
                         (y_avg_reg <= AVG_W'(SCALE_MAX)) &&
                         (y_avg_reg >= -AVG_W'(SCALE_MAX)))
        else $error("average out of range");

endmodule

FILE: hdl/jsfd_ctrl.sv
// sequencing state machine for one item at a time
`timescale 1ns / 1ps

module jsfd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output jsfd_pkg::ctrl_cmd_t cmd,
    input  jsfd_pkg::ctrl_sts_t sts
);
    import jsfd_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (s_tvalid) state_next = ST_LOAD;
            ST_LOAD:     state_next = ST_SCALE;
            ST_SCALE:    if (sts.div_done) state_next = ST_UPDATE;
            ST_UPDATE:   state_next = ST_AVG_LOAD;
            ST_AVG_LOAD: state_next = ST_AVG;
            ST_AVG:      if (sts.div_done) state_next = ST_DONE;
            ST_DONE:     if (sts.out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_LOAD:     cmd.scale_start = 1'b1;
            ST_SCALE:    ;
            ST_UPDATE:   cmd.update = 1'b1;
            ST_AVG_LOAD: cmd.avg_start = 1'b1;
            ST_AVG:      ;
            ST_DONE:     cmd.out_load = sts.out_free;
            default:     ;
        endcase
    end

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded over a waiting item");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.scale_start || cmd.avg_start) |=> !sts.div_done)
        else $error("divider did not start");

endmodule
